FILE: rtl/divider_and_timer_counter_defines.svh
// Assertion macros for the divider and timer/counter block.
// Used by the port checker; expects signals named clock and reset in scope.
`ifndef DIVIDER_AND_TIMER_COUNTER_DEFINES_SVH
`define DIVIDER_AND_TIMER_COUNTER_DEFINES_SVH

// Same-cycle implication, off while reset is high
`define DTC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define DTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define DTC_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/dtc_pkg.sv
// Shared types, codes and microcode ROM for the divider and timer/counter.
// No dependencies; used by dtc_seq and divider_and_timer_counter.
`default_nettype none

package dtc_pkg;

   // Divider accumulator period in machine cycles
   localparam int unsigned DIV_PERIOD   = 256;
   localparam logic [8:0]  DIV_PERIOD_W = 9'(DIV_PERIOD);

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEL_DIVIDER = 2'd0,
      SEL_COUNTER = 2'd1,
      SEL_MODULO  = 2'd2,
      SEL_CONTROL = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      RATE_1024 = 2'd0,
      RATE_16   = 2'd1,
      RATE_64   = 2'd2,
      RATE_256  = 2'd3
   } rate_type;

   localparam int unsigned CTL_ENABLE_BIT = 2;

   // Microcode addresses
   typedef logic [2:0] step_type;
   localparam step_type STEP_FETCH    = 3'd0;
   localparam step_type STEP_DISPATCH = 3'd1;
   localparam step_type STEP_TICK_ADD = 3'd2;
   localparam step_type STEP_TIMER    = 3'd3;
   localparam step_type STEP_EMIT     = 3'd4;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_NO_REQ   = 3'd1,
      COND_NOT_TICK = 3'd2,
      COND_MORE     = 3'd3,
      COND_OUT_BUSY = 3'd4
   } cond_type;

   // One control word: datapath actions, then jump target on a hit, else next
   typedef struct packed {
      logic     accept;
      logic     tick_add;
      logic     timer_step;
      logic     emit;
      cond_type cond;
      step_type jump_to;
      step_type next_to;
   } ctrl_word_type;

   // Datapath flags the sequencer branches on
   typedef struct packed {
      logic req_valid;
      logic not_tick;
      logic more;
      logic out_busy;
   } status_type;

   // Timer period in clocks for each rate code
   function automatic logic [10:0] timer_period(input logic [1:0] rate);
      logic [10:0] period;
      case (rate_type'(rate))
         RATE_1024: period = 11'd1024;
         RATE_16:   period = 11'd16;
         RATE_64:   period = 11'd64;
         RATE_256:  period = 11'd256;
         default:   period = 11'd1024;
      endcase
      return period;
   endfunction

   // Microcode program
   function automatic ctrl_word_type micro_rom(input step_type step);
      ctrl_word_type word;
      word = '{accept: 1'b0, tick_add: 1'b0, timer_step: 1'b0, emit: 1'b0,
               cond: COND_ALWAYS, jump_to: STEP_FETCH, next_to: STEP_FETCH};
      case (step)
         STEP_FETCH: begin
            word.accept  = 1'b1;
            word.cond    = COND_NO_REQ;
            word.jump_to = STEP_FETCH;
            word.next_to = STEP_DISPATCH;
         end
         STEP_DISPATCH: begin
            word.cond    = COND_NOT_TICK;
            word.jump_to = STEP_EMIT;
            word.next_to = STEP_TICK_ADD;
         end
         STEP_TICK_ADD: begin
            word.tick_add = 1'b1;
            word.cond     = COND_ALWAYS;
            word.jump_to  = STEP_TIMER;
            word.next_to  = STEP_TIMER;
         end
         STEP_TIMER: begin
            word.timer_step = 1'b1;
            word.cond       = COND_MORE;
            word.jump_to    = STEP_TIMER;
            word.next_to    = STEP_EMIT;
         end
         STEP_EMIT: begin
            word.emit    = 1'b1;
            word.cond    = COND_OUT_BUSY;
            word.jump_to = STEP_EMIT;
            word.next_to = STEP_FETCH;
         end
         default: begin
            word.cond    = COND_ALWAYS;
            word.jump_to = STEP_FETCH;
         end
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/divider_and_timer_counter.sv
// Top level of the divider and timer/counter: register datapath and output stage.
// Depends on dtc_pkg and dtc_seq.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  req     | req_valid | req_stall | req_cmd, req_reg_select, req_write_data,
//          |           |           | req_machine_cycles
//  rsp     | rsp_valid | rsp_stall | rsp_read_data, rsp_timer_irq
//
// A read, write or unused command passes through the fetch, dispatch and emit
// steps. A tick passes through fetch, dispatch, tick-add and then the timer step,
// which repeats while the timer is on and a whole period is left, before emit.
// The result is loaded into the output register in the emit step.
// A stalled result holds the sequencer in its emit step; req_stall stays high.
// Synchronous reset clears the state registers and the result valid to zero
// and returns the sequencer to the fetch step.
`default_nettype none

module divider_and_timer_counter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [1:0] req_reg_select,
   input  wire logic [7:0] req_write_data,
   input  wire logic [4:0] req_machine_cycles,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_timer_irq
);
   import dtc_pkg::*;

   ctrl_word_type ctrl;
   status_type    status;

   // Latched request beat
   cmd_type    cmd_ff;
   sel_type    sel_ff;
   logic [7:0] wdata_ff;
   logic [4:0] cycles_ff;

   // Architectural state
   logic [8:0]  div_accum_ff,   div_accum_in;
   logic [10:0] timer_accum_ff, timer_accum_in;
   logic [7:0]  divider_ff,     divider_in;
   logic [7:0]  counter_ff,     counter_in;
   logic [7:0]  modulo_ff,      modulo_in;
   logic [2:0]  control_ff,     control_in;
   logic        irq_ff,         irq_in;

   // Output stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff,  rsp_data_in;
   logic       rsp_irq_ff,   rsp_irq_in;

   logic        req_take;
   logic        emit_fire;
   logic        timer_on;
   logic [10:0] period;
   logic [8:0]  div_sum;
   logic [10:0] timer_sum;
   logic [7:0]  read_value;

   dtc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   assign req_stall = !ctrl.accept;
   assign req_take  = req_valid && ctrl.accept;

   assign timer_on = control_ff[CTL_ENABLE_BIT];
   assign period   = timer_period(control_ff[1:0]);
   assign div_sum  = div_accum_ff + {4'b0000, cycles_ff};
   assign timer_sum = timer_accum_ff + {4'b0000, cycles_ff, 2'b00};

   // Flags for the sequencer
   assign status.req_valid = req_valid;
   assign status.not_tick  = (cmd_ff != CMD_TICK);
   assign status.more      = timer_on && (timer_accum_ff >= period);
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   assign emit_fire = ctrl.emit && !status.out_busy;

   // Select the register a read returns
   always_comb begin
      case (sel_ff)
         SEL_DIVIDER: read_value = divider_ff;
         SEL_COUNTER: read_value = counter_ff;
         SEL_MODULO:  read_value = modulo_ff;
         SEL_CONTROL: read_value = {5'b00000, control_ff};
         default:     read_value = 8'h00;
      endcase
   end

   // Next state of the timer registers
   always_comb begin
      div_accum_in   = div_accum_ff;
      timer_accum_in = timer_accum_ff;
      divider_in     = divider_ff;
      counter_in     = counter_ff;
      modulo_in      = modulo_ff;
      control_in     = control_ff;
      irq_in         = irq_ff;

      if (req_take) begin
         irq_in = 1'b0;
      end

      // Add the tick to the divider accumulator, and to the timer one while it is on
      if (ctrl.tick_add) begin
         if (div_sum >= DIV_PERIOD_W) begin
            div_accum_in = div_sum - DIV_PERIOD_W;
            divider_in   = divider_ff + 8'd1;
         end else begin
            div_accum_in = div_sum;
         end
         if (timer_on) begin
            timer_accum_in = timer_sum;
         end
      end

      // Step the counter once per whole period, reload on wrap
      if (ctrl.timer_step && status.more) begin
         timer_accum_in = timer_accum_ff - period;
         if (counter_ff == 8'hFF) begin
            counter_in = modulo_ff;
            irq_in     = 1'b1;
         end else begin
            counter_in = counter_ff + 8'd1;
         end
      end

      // Store a register write as the result goes out
      if (emit_fire && (cmd_ff == CMD_WRITE)) begin
         case (sel_ff)
            SEL_DIVIDER: divider_in = wdata_ff;
            SEL_COUNTER: counter_in = wdata_ff;
            SEL_MODULO:  modulo_in  = wdata_ff;
            SEL_CONTROL: control_in = wdata_ff[2:0];
            default:     control_in = control_ff;
         endcase
      end
   end

   // Load or drop the result beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = (cmd_ff == CMD_READ) ? read_value : 8'h00;
         rsp_irq_in   = irq_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= cmd_type'(req_cmd);
         sel_ff    <= sel_type'(req_reg_select);
         wdata_ff  <= req_write_data;
         cycles_ff <= req_machine_cycles;
      end
   end

   // Hold the state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         div_accum_ff   <= '0;
         timer_accum_ff <= '0;
         divider_ff     <= '0;
         counter_ff     <= '0;
         modulo_ff      <= '0;
         control_ff     <= '0;
         irq_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         div_accum_ff   <= div_accum_in;
         timer_accum_ff <= timer_accum_in;
         divider_ff     <= divider_in;
         counter_ff     <= counter_in;
         modulo_ff      <= modulo_in;
         control_ff     <= control_in;
         irq_ff         <= irq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_timer_irq = rsp_irq_ff;

endmodule

`default_nettype wire

FILE: rtl/dtc_seq.sv
// Microcode sequencer: step counter, control ROM lookup and branch select.
// Depends on dtc_pkg.
`default_nettype none

module dtc_seq (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dtc_pkg::status_type status,
   output dtc_pkg::ctrl_word_type  ctrl
);
   import dtc_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     cond_hit;

   // Fetch the control word for the current step
   assign ctrl = micro_rom(step_ff);

   // Evaluate the branch condition
   always_comb begin
      case (ctrl.cond)
         COND_ALWAYS:   cond_hit = 1'b1;
         COND_NO_REQ:   cond_hit = !status.req_valid;
         COND_NOT_TICK: cond_hit = status.not_tick;
         COND_MORE:     cond_hit = status.more;
         COND_OUT_BUSY: cond_hit = status.out_busy;
         default:       cond_hit = 1'b1;
      endcase
   end

   assign step_in = cond_hit ? ctrl.jump_to : ctrl.next_to;

   // Advance the step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dtc_check.sv
// Port-level checker for the divider and timer/counter, bound to the top level.
// Depends on divider_and_timer_counter_defines.svh.
`default_nettype none
`include "divider_and_timer_counter_defines.svh"

module dtc_check (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_timer_irq
);

   // A stalled result beat holds
   `DTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data) && $stable(rsp_timer_irq), "result beat changed while stalled")

   // One item at a time: after a request beat the input stalls
   `DTC_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall && !$rose(rsp_valid), "request accepted while another item is in work")

   // An interrupt only comes with a tick, whose read data is zero
   `DTC_ASSERT_SAME(a_irq_no_data, rsp_valid && rsp_timer_irq, rsp_read_data == 8'h00, "interrupt result carries read data")

   // Reset empties the output and opens the input
   `DTC_ASSERT_ALWAYS_NEXT(a_reset_idle, reset, !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind divider_and_timer_counter dtc_check u_dtc_check (.*);

`default_nettype wire

FILE: test/tb_divider_and_timer_counter.sv
`timescale 1ns / 1ps
// Self-checking bench for divider_and_timer_counter: directed and random beats,
// with random idling on both channels. Needs dtc_pkg and the block's RTL only.

module tb_divider_and_timer_counter;
   import dtc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int unsigned RANDOM_BEATS = 2000;
   localparam int unsigned DRAIN_AT     = 1000;
   localparam int unsigned HOLD_AFTER   = 600;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned SETTLE       = 100;
   localparam int unsigned MAX_REPORTS  = 50;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_irq;
   } result_type;

   // Timer state mirror plus the queue of results still owed by the block
   class timer_scoreboard;
      int unsigned div_acc;
      int unsigned tmr_acc;
      logic [7:0]  div_reg;
      logic [7:0]  cnt_reg;
      logic [7:0]  mod_reg;
      logic [2:0]  ctl_reg;
      result_type  expected_results[$];
      int          errors;

      function new();
         div_acc = 0;
         tmr_acc = 0;
         div_reg = '0;
         cnt_reg = '0;
         mod_reg = '0;
         ctl_reg = '0;
         errors  = 0;
      endfunction

      function int unsigned period_of(logic [1:0] rate);
         int unsigned clocks;
         case (rate_type'(rate))
            RATE_1024: clocks = 1024;
            RATE_16:   clocks = 16;
            RATE_64:   clocks = 64;
            default:   clocks = 256;
         endcase
         return clocks;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Update the mirror for one accepted beat and queue its result
      function void note_beat(cmd_type cmd, sel_type sel, logic [7:0] data,
                              logic [4:0] cycles);
         result_type  res;
         int unsigned period;
         res = '0;
         case (cmd)
            CMD_TICK: begin
               div_acc += cycles;
               if (div_acc >= DIV_PERIOD) begin
                  div_acc -= DIV_PERIOD;
                  div_reg++;
               end
               if (ctl_reg[CTL_ENABLE_BIT]) begin
                  tmr_acc += 4 * cycles;
                  period = period_of(ctl_reg[1:0]);
                  // step once per whole period held, reloading on every wrap
                  while (tmr_acc >= period) begin
                     cnt_reg++;
                     if (cnt_reg == 8'h00) begin
                        cnt_reg       = mod_reg;
                        res.timer_irq = 1'b1;
                     end
                     tmr_acc -= period;
                  end
               end
            end
            CMD_READ: begin
               case (sel)
                  SEL_DIVIDER: res.read_data = div_reg;
                  SEL_COUNTER: res.read_data = cnt_reg;
                  SEL_MODULO:  res.read_data = mod_reg;
                  default:     res.read_data = {5'b0, ctl_reg};
               endcase
            end
            CMD_WRITE: begin
               case (sel)
                  SEL_DIVIDER: div_reg = data;
                  SEL_COUNTER: cnt_reg = data;
                  SEL_MODULO:  mod_reg = data;
                  default:     ctl_reg = data[2:0];
               endcase
            end
            default: ;
         endcase
         expected_results.push_back(res);
      endfunction

      // Compare one accepted result with the oldest expectation
      function void check_beat(logic [7:0] rd, logic irq);
         result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected result, read_data %02h timer_irq %b",
                        $time, rd, irq);
            return;
         end
         want = expected_results.pop_front();
         if (rd !== want.read_data) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: read_data expected %02h actual %02h",
                        $time, want.read_data, rd);
         end
         if (irq !== want.timer_irq) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: timer_irq expected %b actual %b",
                        $time, want.timer_irq, irq);
         end
      endfunction
   endclass

   logic       clock;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd            = '0;
   logic [1:0] req_reg_select     = '0;
   logic [7:0] req_write_data     = '0;
   logic [4:0] req_machine_cycles = '0;
   logic       rsp_valid;
   logic       rsp_stall          = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_timer_irq;

   timer_scoreboard sb = new();
   int unsigned     cycle_count = 0;

   divider_and_timer_counter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_reg_select     (req_reg_select),
      .req_write_data     (req_write_data),
      .req_machine_cycles (req_machine_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_timer_irq      (rsp_timer_irq)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one beat, hold it until accepted, then idle for a random gap
   task automatic send_beat(input cmd_type cmd, input sel_type sel,
                            input logic [7:0] data, input logic [4:0] cycles,
                            input bit calm);
      int gap;
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_reg_select     <= sel;
      req_write_data     <= data;
      req_machine_cycles <= cycles;
      do @(posedge clock); while (req_stall);
      sb.note_beat(cmd, sel, data, cycles);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("CHECK FAILED");
      $finish;
   end

   // Result side: check accepted beats and drive stall
   initial begin
      int stall_left;
      int results_seen;
      bit held;
      stall_left   = 0;
      results_seen = 0;
      held         = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_beat(rsp_read_data, rsp_timer_irq);
            results_seen++;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            // hold off once for a long stretch so the block backs up
            if (!held && results_seen >= HOLD_AFTER) begin
               held       = 1'b1;
               stall_left = HOLD_CYCLES;
            end else if ((cycle_count / 400) % 5 == 2) begin
               stall_left = 0;
            end else begin
               stall_left = pick_gap();
            end
         end
      end
   end

   // Stimulus
   initial begin
      cmd_type    cmd;
      sel_type    sel;
      logic [7:0] data;
      logic [4:0] cycles;
      int         r;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values
      send_beat(CMD_READ,  SEL_DIVIDER, 8'h00, 5'd0,  1'b0);
      send_beat(CMD_READ,  SEL_CONTROL, 8'hFF, 5'd31, 1'b0);
      // Enable at rate 256; upper control bits must be dropped
      send_beat(CMD_WRITE, SEL_MODULO,  8'hFF, 5'd0,  1'b0);
      send_beat(CMD_WRITE, SEL_CONTROL, 8'hFF, 5'd0,  1'b0);
      send_beat(CMD_READ,  SEL_CONTROL, 8'h00, 5'd0,  1'b0);
      // Counter wraps past 8'hFF and reloads the modulo
      send_beat(CMD_WRITE, SEL_COUNTER, 8'hFF, 5'd0,  1'b0);
      send_beat(CMD_TICK,  SEL_DIVIDER, 8'h00, 5'd31, 1'b0);
      send_beat(CMD_TICK,  SEL_DIVIDER, 8'h00, 5'd31, 1'b0);
      send_beat(CMD_TICK,  SEL_DIVIDER, 8'h00, 5'd31, 1'b0);
      // Switch to the fast rate with clocks left over, then a zero-length tick
      send_beat(CMD_WRITE, SEL_CONTROL, 8'h05, 5'd0,  1'b0);
      send_beat(CMD_TICK,  SEL_COUNTER, 8'hFF, 5'd0,  1'b0);
      send_beat(CMD_READ,  SEL_COUNTER, 8'h00, 5'd0,  1'b0);
      // Timer off: accumulator and counter hold
      send_beat(CMD_WRITE, SEL_CONTROL, 8'hF8, 5'd0,  1'b0);
      send_beat(CMD_TICK,  SEL_MODULO,  8'h00, 5'd31, 1'b0);
      send_beat(CMD_READ,  SEL_COUNTER, 8'h00, 5'd0,  1'b0);
      // Divider write stores the byte rather than clearing
      send_beat(CMD_WRITE, SEL_DIVIDER, 8'hA5, 5'd0,  1'b0);
      send_beat(CMD_READ,  SEL_DIVIDER, 8'h00, 5'd0,  1'b0);
      // Unused command leaves everything alone
      send_beat(CMD_NONE,  SEL_CONTROL, 8'hFF, 5'd31, 1'b0);
      // Rate 64 with modulo zero, then ticks that step the counter through a wrap
      send_beat(CMD_WRITE, SEL_MODULO,  8'h00, 5'd0,  1'b0);
      send_beat(CMD_WRITE, SEL_COUNTER, 8'hFE, 5'd0,  1'b0);
      send_beat(CMD_WRITE, SEL_CONTROL, 8'h06, 5'd0,  1'b0);
      repeat (3) send_beat(CMD_TICK, SEL_CONTROL, 8'h55, 5'd31, 1'b0);
      send_beat(CMD_READ,  SEL_MODULO,  8'h00, 5'd0,  1'b0);

      // Random beats, mostly ticks with the timer running
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55)      cmd = CMD_TICK;
         else if (r < 75) cmd = CMD_READ;
         else if (r < 95) cmd = CMD_WRITE;
         else             cmd = CMD_NONE;
         sel    = sel_type'($urandom_range(0, 3));
         data   = 8'($urandom_range(0, 255));
         cycles = 5'($urandom_range(0, 31));
         // favor counter values close to a wrap and an enabled timer
         if (cmd == CMD_WRITE && sel == SEL_COUNTER && $urandom_range(0, 1))
            data[7:4] = 4'hF;
         if (cmd == CMD_WRITE && sel == SEL_CONTROL && $urandom_range(0, 3) != 0)
            data[CTL_ENABLE_BIT] = 1'b1;
         if (i == DRAIN_AT)
            drain_results();
         send_beat(cmd, sel, data, cycles, (i / 150) % 5 == 3);
      end

      // Wait out the last results, then let the block settle
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
